// ===== hw/rtl/rvx_pkg.sv =====
// Package for the register VM execute unit: command and fault codes,
// sequencer state type, default store sizes and field widths.
// No dependencies.
package rvx_pkg;

	localparam int DEF_STACK_DEPTH = 1024;
	localparam int DEF_MEM_WORDS   = 1024;
	localparam int DEF_CONST_WORDS = 1024;

	localparam int CMD_W   = 5;
	localparam int REGID_W = 8;
	localparam int WORD_W  = 32;
	localparam int PC_W    = 16;
	localparam int LEN_W   = 3;
	localparam int FAULT_W = 4;
	localparam int LIMIT_W = 11;
	localparam int NUM_REGS = 10;
	localparam int RIDX_W  = 4;

	localparam logic [CMD_W-1:0] CMD_MOV   = 5'd0;
	localparam logic [CMD_W-1:0] CMD_CONST = 5'd1;
	localparam logic [CMD_W-1:0] CMD_PUSH  = 5'd2;
	localparam logic [CMD_W-1:0] CMD_POP   = 5'd3;
	localparam logic [CMD_W-1:0] CMD_ADD   = 5'd4;
	localparam logic [CMD_W-1:0] CMD_SUB   = 5'd5;
	localparam logic [CMD_W-1:0] CMD_MUL   = 5'd6;
	localparam logic [CMD_W-1:0] CMD_DIV   = 5'd7;
	localparam logic [CMD_W-1:0] CMD_MOD   = 5'd8;
	localparam logic [CMD_W-1:0] CMD_AND   = 5'd9;
	localparam logic [CMD_W-1:0] CMD_OR    = 5'd10;
	localparam logic [CMD_W-1:0] CMD_XOR   = 5'd11;
	localparam logic [CMD_W-1:0] CMD_READ  = 5'd12;
	localparam logic [CMD_W-1:0] CMD_WRITE = 5'd13;
	localparam logic [CMD_W-1:0] CMD_JMP   = 5'd14;
	localparam logic [CMD_W-1:0] CMD_JZ    = 5'd15;
	localparam logic [CMD_W-1:0] CMD_JNZ   = 5'd16;
	localparam logic [CMD_W-1:0] CMD_JN    = 5'd17;
	localparam logic [CMD_W-1:0] CMD_JNN   = 5'd18;
	localparam logic [CMD_W-1:0] CMD_RET   = 5'd19;
	localparam logic [CMD_W-1:0] CMD_LDC   = 5'd20;

	localparam logic [FAULT_W-1:0] FLT_OK       = 4'd0;
	localparam logic [FAULT_W-1:0] FLT_BAD_REG  = 4'd1;
	localparam logic [FAULT_W-1:0] FLT_BAD_OP   = 4'd2;
	localparam logic [FAULT_W-1:0] FLT_OVERFLOW = 4'd3;
	localparam logic [FAULT_W-1:0] FLT_UNDERFLOW = 4'd4;
	localparam logic [FAULT_W-1:0] FLT_CONST_IDX = 4'd5;
	localparam logic [FAULT_W-1:0] FLT_MEM_ADDR = 4'd6;
	localparam logic [FAULT_W-1:0] FLT_DIV_ZERO = 4'd7;
	localparam logic [FAULT_W-1:0] FLT_RAN_OFF  = 4'd8;
	localparam logic [FAULT_W-1:0] FLT_CONST_FULL = 4'd9;

	localparam logic [0:0] CFG_CODE_LENGTH  = 1'b0;
	localparam logic [0:0] CFG_MEMORY_LIMIT = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_LOAD  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		SRC_STACK = 2'd0,
		SRC_CONST = 2'd1,
		SRC_MEM   = 2'd2
	} load_src_t;

endpackage

// ===== hw/rtl/rvx_if.sv =====
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on rvx_pkg.
interface rvx_instr_if import rvx_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic [REGID_W-1:0]        first_reg;
	logic [REGID_W-1:0]        second_reg;
	logic signed [WORD_W-1:0]  immediate;
	logic [PC_W-1:0]           target;
	logic [LEN_W-1:0]          instr_length;

	modport source (output valid, command, first_reg, second_reg, immediate, target,
		instr_length, input ready);
	modport sink (input valid, command, first_reg, second_reg, immediate, target,
		instr_length, output ready);
endinterface

interface rvx_result_if import rvx_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [PC_W-1:0]           next_pc;
	logic signed [WORD_W-1:0]  written_value;
	logic                      jump_taken;
	logic                      zero_state;
	logic                      negative_state;
	logic                      finished;
	logic [FAULT_W-1:0]        fault;

	modport source (output valid, next_pc, written_value, jump_taken, zero_state,
		negative_state, finished, fault, input ready);
	modport sink (input valid, next_pc, written_value, jump_taken, zero_state,
		negative_state, finished, fault, output ready);
endinterface

// ===== hw/rtl/register_vm_execute.sv =====
// Execute unit of a small register VM. Every command passes from accept through
// EXEC to FIN; const, pop and memory read add LOAD (registered store read), and
// div and mod add DIV (one quotient bit per cycle in a shared restoring divider).
// One instruction at a time; the next beat is accepted once the sequencer is idle,
// so a new beat waits until the last one has committed, while result beats drain at once.
// A result beat held by the sink stalls the commit and with it the input.
// Reset: asynchronous; afterwards the data memory is zeroed one word per cycle,
// all MEM_WORDS words, before the first instruction beat is accepted.
module register_vm_execute import rvx_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int MEM_WORDS   = DEF_MEM_WORDS,
	parameter int CONST_WORDS = DEF_CONST_WORDS
) (
	input  logic               clk,
	input  logic               arst_n,
	rvx_instr_if.sink          instr,
	rvx_result_if.source       result,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [PC_W-1:0]    wr_data
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int CAW = (CONST_WORDS > 1) ? $clog2(CONST_WORDS) : 1;
	localparam int CCW = $clog2(CONST_WORDS + 1);
	localparam int MCW = $clog2(MEM_WORDS + 1);

	state_t state_q;

	// configuration
	logic [PC_W-1:0]    code_length_q;
	logic [LIMIT_W-1:0] memory_limit_q;

	// architectural state
	logic [WORD_W-1:0] rf_q [NUM_REGS];
	logic              zero_q, neg_q;
	logic [PC_W-1:0]   pc_q;
	logic [SCW-1:0]    stk_cnt_q;
	logic [CCW-1:0]    cst_cnt_q;
	logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
	logic [WORD_W-1:0] cst_mem [CONST_WORDS];
	logic [WORD_W-1:0] dat_mem [MEM_WORDS];
	logic [MCW-1:0]    clr_q;

	// latched instruction
	logic [CMD_W-1:0]   cmd_q;
	logic               a_ok_q, b_ok_q;
	logic [RIDX_W-1:0]  a_idx_q;
	logic [WORD_W-1:0]  imm_q, a_q, b_q;
	logic [PC_W-1:0]    tgt_q;
	logic [LEN_W-1:0]   len_q;

	// working results
	logic [WORD_W-1:0]  res_q;
	logic [PC_W-1:0]    npc_q;
	logic [FAULT_W-1:0] fault_q;
	logic               wr_reg_q, alu_q, jump_q, fin_q, div_q, neg_res_q;
	load_src_t          src_q;

	// divider
	logic [WORD_W-1:0]  rem_q, quo_q, mb_q;
	logic [4:0]         dcnt_q;
	logic               want_rem_q;

	// registered store reads
	logic [WORD_W-1:0]  stk_rd_q, cst_rd_q, dat_rd_q;

	// output register
	logic               out_valid_q;
	logic [PC_W-1:0]    o_pc_q;
	logic [WORD_W-1:0]  o_val_q;
	logic               o_jump_q, o_zero_q, o_neg_q, o_fin_q;
	logic [FAULT_W-1:0] o_fault_q;

	logic               accept, commit;
	logic [RIDX_W-1:0]  ia, ib;
	logic               ia_ok, ib_ok;
	logic [FAULT_W-1:0] ex_fault;
	logic [WORD_W-1:0]  alu_res;
	logic               mem_ok, take;
	logic [WORD_W-1:0]  tgt_ext;
	logic [SAW-1:0]     stk_raddr;
	logic [CAW-1:0]     cst_raddr;
	logic [MAW-1:0]     dat_addr;
	logic               dat_we;
	logic [WORD_W-1:0]  dat_wdata;
	logic [WORD_W:0]    trial;
	logic [WORD_W-1:0]  div_val, fin_val;
	logic               fin_zero, fin_neg;

	assign accept = (state_q == ST_IDLE) && instr.valid;
	assign instr.ready = (state_q == ST_IDLE);
	assign commit = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	assign ia_ok = (instr.first_reg >= 8'd1) && (instr.first_reg <= 8'd10);
	assign ib_ok = (instr.second_reg >= 8'd1) && (instr.second_reg <= 8'd10);
	assign ia = ia_ok ? RIDX_W'(instr.first_reg - 8'd1) : '0;
	assign ib = ib_ok ? RIDX_W'(instr.second_reg - 8'd1) : '0;

	assign tgt_ext = WORD_W'(tgt_q);
	assign mem_ok = !b_q[WORD_W-1] && (b_q < WORD_W'(memory_limit_q))
		&& (b_q < WORD_W'(MEM_WORDS));

	always_comb begin
		case (cmd_q)
			CMD_ADD: alu_res = a_q + b_q;
			CMD_SUB: alu_res = a_q - b_q;
			CMD_MUL: alu_res = a_q * b_q;
			CMD_AND: alu_res = a_q & b_q;
			CMD_OR:  alu_res = a_q | b_q;
			default: alu_res = a_q ^ b_q;
		endcase
	end

	always_comb begin
		unique case (cmd_q)
			CMD_JMP: take = 1'b1;
			CMD_JZ:  take = zero_q;
			CMD_JNZ: take = !zero_q;
			CMD_JN:  take = neg_q;
			CMD_JNN: take = !neg_q;
			default: take = 1'b0;
		endcase
	end

	// fault priority: ldc checks only const full; others ran off code, then bad opcode or per-command checks
	always_comb begin
		ex_fault = FLT_OK;
		if (cmd_q == CMD_LDC) begin
			if (cst_cnt_q == CCW'(CONST_WORDS)) ex_fault = FLT_CONST_FULL;
		end else if (pc_q >= code_length_q) begin
			ex_fault = FLT_RAN_OFF;
		end else begin
			case (cmd_q) inside
				CMD_MOV, CMD_PUSH, CMD_CONST: begin
					if (!a_ok_q) ex_fault = FLT_BAD_REG;
					else if (cmd_q == CMD_CONST && 32'(cst_cnt_q) <= tgt_ext)
						ex_fault = FLT_CONST_IDX;
					else if (cmd_q == CMD_PUSH
							&& 32'(stk_cnt_q) + 32'd1 >= 32'(STACK_DEPTH))
						ex_fault = FLT_OVERFLOW;
				end
				CMD_POP: begin
					if (stk_cnt_q == '0) ex_fault = FLT_UNDERFLOW;
					else if (!a_ok_q) ex_fault = FLT_BAD_REG;
				end
				[CMD_ADD:CMD_XOR]: begin
					if (!a_ok_q || !b_ok_q) ex_fault = FLT_BAD_REG;
					else if ((cmd_q == CMD_DIV || cmd_q == CMD_MOD) && b_q == '0)
						ex_fault = FLT_DIV_ZERO;
				end
				CMD_READ, CMD_WRITE: begin
					if (!a_ok_q || !b_ok_q) ex_fault = FLT_BAD_REG;
					else if (!mem_ok) ex_fault = FLT_MEM_ADDR;
				end
				[CMD_JMP:CMD_RET]: ex_fault = FLT_OK;
				default: ex_fault = FLT_BAD_OP;
			endcase
		end
	end

	assign stk_raddr = SAW'(stk_cnt_q - SCW'(1));
	assign cst_raddr = tgt_ext[CAW-1:0];
	assign dat_addr  = (state_q == ST_CLEAR) ? clr_q[MAW-1:0] : b_q[MAW-1:0];
	assign dat_we    = (state_q == ST_CLEAR)
		|| (state_q == ST_EXEC && cmd_q == CMD_WRITE && ex_fault == FLT_OK);
	assign dat_wdata = (state_q == ST_CLEAR) ? '0 : a_q;

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_raddr];
		cst_rd_q <= cst_mem[cst_raddr];
		dat_rd_q <= dat_mem[dat_addr];
		if (dat_we) dat_mem[dat_addr] <= dat_wdata;
		if (state_q == ST_EXEC && ex_fault == FLT_OK) begin
			if (cmd_q == CMD_PUSH) stk_mem[stk_cnt_q[SAW-1:0]] <= a_q;
			if (cmd_q == CMD_LDC) cst_mem[cst_cnt_q[CAW-1:0]] <= imm_q;
		end
	end

	assign trial = {rem_q, quo_q[WORD_W-1]} - {1'b0, mb_q};

	// sign fix of the unsigned quotient or remainder
	assign div_val = want_rem_q ? (neg_res_q ? -rem_q : rem_q)
		: (neg_res_q ? -quo_q : quo_q);
	assign fin_val = div_q ? div_val : res_q;
	always_comb begin
		fin_zero = zero_q;
		fin_neg  = neg_q;
		if (alu_q && fault_q == FLT_OK) begin
			if (fin_val != '0) begin
				fin_zero = 1'b0;
				fin_neg  = fin_val[WORD_W-1];
			end else begin
				fin_zero = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			code_length_q <= '0;
			memory_limit_q <= LIMIT_W'(1024);
			for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
			zero_q <= 1'b0;
			neg_q <= 1'b0;
			pc_q <= '0;
			stk_cnt_q <= '0;
			cst_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_CODE_LENGTH:  code_length_q <= wr_data;
					CFG_MEMORY_LIMIT: memory_limit_q <= wr_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (commit) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MCW'(1);
					if (clr_q == MCW'(MEM_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (ex_fault != FLT_OK) begin
						state_q <= ST_FIN;
					end else begin
						unique case (cmd_q) inside
							CMD_CONST, CMD_POP, CMD_READ: state_q <= ST_LOAD;
							CMD_DIV, CMD_MOD: state_q <= ST_DIV;
							default: state_q <= ST_FIN;
						endcase
						if (cmd_q == CMD_PUSH) stk_cnt_q <= stk_cnt_q + SCW'(1);
						if (cmd_q == CMD_POP) stk_cnt_q <= stk_cnt_q - SCW'(1);
						if (cmd_q == CMD_LDC) cst_cnt_q <= cst_cnt_q + CCW'(1);
					end
				end
				ST_LOAD: state_q <= ST_FIN;
				ST_DIV: if (dcnt_q == 5'd31) state_q <= ST_FIN;
				ST_FIN: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (fault_q == FLT_OK) begin
							pc_q <= npc_q;
							zero_q <= fin_zero;
							neg_q <= fin_neg;
							if (wr_reg_q) rf_q[a_idx_q] <= fin_val;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= instr.command;
			a_ok_q <= ia_ok;
			b_ok_q <= ib_ok;
			a_idx_q <= ia;
			imm_q  <= instr.immediate;
			tgt_q  <= instr.target;
			len_q  <= instr.instr_length;
			a_q    <= rf_q[ia];
			b_q    <= rf_q[ib];
		end
		if (state_q == ST_EXEC) begin
			fault_q  <= ex_fault;
			npc_q    <= pc_q + PC_W'(len_q);
			res_q    <= '0;
			wr_reg_q <= 1'b0;
			alu_q    <= 1'b0;
			jump_q   <= 1'b0;
			fin_q    <= 1'b0;
			div_q    <= 1'b0;
			src_q    <= SRC_MEM;
			case (cmd_q) inside
				CMD_MOV: begin
					res_q <= imm_q;
					wr_reg_q <= 1'b1;
				end
				CMD_CONST: begin
					src_q <= SRC_CONST;
					wr_reg_q <= 1'b1;
				end
				CMD_POP: begin
					src_q <= SRC_STACK;
					wr_reg_q <= 1'b1;
				end
				CMD_READ: wr_reg_q <= 1'b1;
				CMD_WRITE: res_q <= a_q;
				CMD_ADD, CMD_SUB, CMD_MUL, CMD_AND, CMD_OR, CMD_XOR: begin
					res_q <= alu_res;
					wr_reg_q <= 1'b1;
					alu_q <= 1'b1;
				end
				CMD_DIV, CMD_MOD: begin
					wr_reg_q <= 1'b1;
					alu_q <= 1'b1;
					div_q <= 1'b1;
					want_rem_q <= (cmd_q == CMD_MOD);
					neg_res_q <= (cmd_q == CMD_MOD) ? a_q[WORD_W-1]
						: (a_q[WORD_W-1] ^ b_q[WORD_W-1]);
					quo_q <= a_q[WORD_W-1] ? -a_q : a_q;
					mb_q  <= b_q[WORD_W-1] ? -b_q : b_q;
					rem_q <= '0;
					dcnt_q <= '0;
				end
				[CMD_JMP:CMD_JNN]: begin
					if (take) begin
						npc_q <= tgt_q;
						jump_q <= 1'b1;
					end
				end
				CMD_RET: begin
					npc_q <= pc_q + PC_W'(1);
					fin_q <= 1'b1;
				end
				CMD_LDC: npc_q <= pc_q;
				default: ;
			endcase
		end
		if (state_q == ST_LOAD) begin
			case (src_q)
				SRC_STACK: res_q <= stk_rd_q;
				SRC_CONST: res_q <= cst_rd_q;
				default:   res_q <= dat_rd_q;
			endcase
		end
		if (state_q == ST_DIV) begin
			// one quotient bit per cycle
			dcnt_q <= dcnt_q + 5'd1;
			quo_q <= {quo_q[WORD_W-2:0], !trial[WORD_W]};
			if (!trial[WORD_W]) rem_q <= trial[WORD_W-1:0];
			else rem_q <= {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
		end
		if (commit) begin
			o_fault_q <= fault_q;
			o_zero_q  <= fin_zero;
			o_neg_q   <= fin_neg;
			if (fault_q == FLT_OK) begin
				o_pc_q   <= npc_q;
				o_val_q  <= (wr_reg_q || cmd_q == CMD_WRITE) ? fin_val : '0;
				o_jump_q <= jump_q;
				o_fin_q  <= fin_q;
			end else begin
				o_pc_q   <= pc_q;
				o_val_q  <= '0;
				o_jump_q <= 1'b0;
				o_fin_q  <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.next_pc        = o_pc_q;
	assign result.written_value  = o_val_q;
	assign result.jump_taken     = o_jump_q;
	assign result.zero_state     = o_zero_q;
	assign result.negative_state = o_neg_q;
	assign result.finished       = o_fin_q;
	assign result.fault          = o_fault_q;

endmodule
